// ===== design/wqtm_pkg.sv =====
// Shared types, codes and constants of the wait queue and timer manager.
`default_nettype none
package wqtm_pkg;

   localparam int SLOTS_DEFAULT  = 16;
   localparam int QUEUES_DEFAULT = 8;
   localparam int MAX_WOKEN      = 16;

   localparam logic [63:0] HALF_RANGE = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [2:0] ACT_PREPARE  = 3'd0;
   localparam logic [2:0] ACT_WAKE_ONE = 3'd1;
   localparam logic [2:0] ACT_WAKE_ALL = 3'd2;
   localparam logic [2:0] ACT_CANCEL   = 3'd3;
   localparam logic [2:0] ACT_ABANDON  = 3'd4;
   localparam logic [2:0] ACT_TAKE     = 3'd5;
   localparam logic [2:0] ACT_EXPIRE   = 3'd6;

   localparam logic [1:0] SS_IDLE      = 2'd0;
   localparam logic [1:0] SS_WAITING   = 2'd1;
   localparam logic [1:0] SS_COMPLETED = 2'd2;

   localparam logic [2:0] RSN_NONE        = 3'd0;
   localparam logic [2:0] RSN_TIMED_OUT   = 3'd2;
   localparam logic [2:0] RSN_CANCELLED   = 3'd3;
   localparam logic [2:0] RSN_INTERRUPTED = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  slot_id;
      logic [2:0]  queue_id;
      logic        infinite;
      logic [63:0] timeout_ticks;
      logic [63:0] now_ticks;
      logic [2:0]  wake_reason_in;
      logic [4:0]  budget;
   } wqtm_req_type;

   typedef struct packed {
      logic        status;
      logic        runnable;
      logic [3:0]  woken_slot;
      logic [2:0]  wake_reason;
      logic [4:0]  woken_count;
      logic [31:0] generation;
      logic        last;
   } wqtm_rsp_type;

endpackage
`default_nettype wire

// ===== design/wqtm_cmp.sv =====
// Shared wrap-around deadline compare: a lies before b.
`default_nettype none
module wqtm_cmp (
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             is_before
);
   import wqtm_pkg::*;

   logic [63:0] diff;

   assign diff      = a - b;
   assign is_before = (diff > HALF_RANGE);

endmodule
`default_nettype wire

// ===== design/wait_queue_timer_manager.sv =====
// Top level of the wait queue and timer manager: slot store and sequencer.
// Rejects, abandon and take finish straight from the exec state; prepare adds the slot and,
// for a timed wait, walks the timer list to insert it; wake_all wakes slot by slot and
// expire checks and completes each expired slot in turn.
// One item at a time; busy drops in the cycle after the summary strobe.
// The shared 64-bit deadline compare sets the walk pace.
// Reset clears slot states, queue and timer links, not deadlines; results cannot stall.
`default_nettype none
module wait_queue_timer_manager #(
   parameter int SLOTS  = wqtm_pkg::SLOTS_DEFAULT,
   parameter int QUEUES = wqtm_pkg::QUEUES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire wqtm_pkg::wqtm_req_type req_data,
   output logic                       rsp_valid,
   output wqtm_pkg::wqtm_rsp_type     rsp_data
);
   import wqtm_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int PW = SW + 1;
   localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam logic [PW-1:0] NIL = PW'(SLOTS);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_EXEC  = 9'b000000010,
      ST_PADD  = 9'b000000100,
      ST_PWALK = 9'b000001000,
      ST_WAKE  = 9'b000010000,
      ST_ECHK  = 9'b000100000,
      ST_EDO   = 9'b001000000,
      ST_DONE  = 9'b010000000,
      ST_HOLD  = 9'b100000000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // per-slot store
   logic [1:0]    sstate_ff [SLOTS];
   logic [2:0]    sreason_ff[SLOTS];
   logic [QW-1:0] squeue_ff [SLOTS];
   logic [63:0]   sdl_ff    [SLOTS];
   logic          stimed_ff [SLOTS];
   logic [31:0]   sgen_ff   [SLOTS];
   logic [PW-1:0] qnext_ff  [SLOTS];
   logic [PW-1:0] qprev_ff  [SLOTS];
   logic [PW-1:0] tnext_ff  [SLOTS];
   logic [PW-1:0] tprev_ff  [SLOTS];
   logic          tlinked_ff[SLOTS];
   logic [PW-1:0] qhead_ff  [QUEUES];
   logic [PW-1:0] qtail_ff  [QUEUES];
   logic [PW-1:0] qcount_ff [QUEUES];
   logic [PW-1:0] thead_ff;

   // item and sequencer registers
   wqtm_req_type  req_ff;
   logic [4:0]    cnt_ff;
   logic [PW-1:0] cur_ff;
   logic [PW-1:0] prev_ff;
   logic [63:0]   newdl_ff;
   logic          sum_status_ff;
   logic [2:0]    sum_reason_ff;
   logic [31:0]   sum_gen_ff;
   logic          rsp_valid_ff;
   wqtm_rsp_type  rsp_ff;

   logic [SW-1:0] s_idx;
   logic [QW-1:0] q_idx;
   logic          s_ok, q_ok, r_ok;
   logic [PW-1:0] wake_tgt;
   logic [SW-1:0] ra;
   logic [63:0]   cmp_a;
   logic          cmp_before;
   logic          do_cmp;
   logic [2:0]    cmp_reason;
   logic [QW-1:0] c_q;
   logic [PW-1:0] c_p, c_n, c_tp, c_tn;
   logic [31:0]   gen_new;
   logic [63:0]   dl_sum;

   assign s_idx = SW'(req_ff.slot_id);
   assign q_idx = QW'(req_ff.queue_id);
   assign s_ok  = (int'(req_ff.slot_id) < SLOTS);
   assign q_ok  = (int'(req_ff.queue_id) < QUEUES);
   assign r_ok  = (req_ff.wake_reason_in != RSN_NONE) &&
                  (req_ff.wake_reason_in <= RSN_INTERRUPTED);
   assign wake_tgt = ((req_ff.action == ACT_WAKE_ONE) || (req_ff.action == ACT_WAKE_ALL))
                     ? qhead_ff[q_idx] : PW'(s_idx);

   // single read address into the slot store
   always_comb begin
      unique case (state_ff)
         ST_WAKE:          ra = wake_tgt[SW-1:0];
         ST_PWALK:         ra = cur_ff[SW-1:0];
         ST_ECHK, ST_EDO:  ra = thead_ff[SW-1:0];
         default:          ra = s_idx;
      endcase
   end

   // shared compare: walk uses the new deadline, expire uses now
   assign cmp_a = state_ff[3] ? newdl_ff : req_ff.now_ticks;

   wqtm_cmp u_cmp (
      .a         (cmp_a),
      .b         (sdl_ff[ra]),
      .is_before (cmp_before)
   );

   assign gen_new = (sgen_ff[ra] + 32'd1 == 32'd0) ? 32'd1 : sgen_ff[ra] + 32'd1;
   assign dl_sum  = req_ff.infinite ? 64'd0 : req_ff.now_ticks + req_ff.timeout_ticks;

   assign c_q  = squeue_ff[ra];
   assign c_p  = qprev_ff[ra];
   assign c_n  = qnext_ff[ra];
   assign c_tp = tprev_ff[ra];
   assign c_tn = tnext_ff[ra];

   // completion of the slot at the read address
   always_comb begin
      do_cmp     = 1'b0;
      cmp_reason = req_ff.wake_reason_in;
      unique case (state_ff)
         ST_EXEC: begin
            if (req_ff.action == ACT_ABANDON && s_ok && sstate_ff[ra] == SS_WAITING) begin
               do_cmp     = 1'b1;
               cmp_reason = RSN_CANCELLED;
            end
         end
         ST_WAKE: begin
            do_cmp = !((req_ff.action == ACT_WAKE_ALL) &&
                       ((wake_tgt >= NIL) || (cnt_ff >= 5'(MAX_WOKEN))));
         end
         ST_EDO: begin
            do_cmp     = 1'b1;
            cmp_reason = RSN_TIMED_OUT;
         end
         default: ;
      endcase
   end

   // next sequencer state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (req_ff.action)
               ACT_PREPARE:
                  state_in = (s_ok && q_ok && sstate_ff[ra] == SS_IDLE && !tlinked_ff[ra] &&
                              (req_ff.infinite || req_ff.timeout_ticks != 64'd0))
                             ? ST_PADD : ST_DONE;
               ACT_WAKE_ONE:
                  state_in = (r_ok && q_ok && wake_tgt < NIL) ? ST_WAKE : ST_DONE;
               ACT_WAKE_ALL:
                  state_in = (r_ok && q_ok) ? ST_WAKE : ST_DONE;
               ACT_CANCEL:
                  state_in = (r_ok && s_ok && sstate_ff[ra] == SS_WAITING) ? ST_WAKE : ST_DONE;
               ACT_EXPIRE: state_in = ST_ECHK;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_PADD:  state_in = req_ff.infinite ? ST_DONE : ST_PWALK;
         ST_PWALK: if (cur_ff >= NIL || cmp_before) state_in = ST_DONE;
         ST_WAKE:  if (!do_cmp || req_ff.action != ACT_WAKE_ALL) state_in = ST_DONE;
         ST_ECHK: begin
            if (thead_ff >= NIL || cnt_ff >= req_ff.budget ||
                cnt_ff >= 5'(MAX_WOKEN) || cmp_before)
               state_in = ST_DONE;
            else
               state_in = ST_EDO;
         end
         ST_EDO:  state_in = ST_ECHK;
         ST_DONE: state_in = ST_HOLD;
         ST_HOLD: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thead_ff     <= NIL;
         for (int i = 0; i < SLOTS; i++) begin
            sstate_ff[i]  <= SS_IDLE;
            sreason_ff[i] <= RSN_NONE;
            squeue_ff[i]  <= '0;
            stimed_ff[i]  <= 1'b0;
            sgen_ff[i]    <= '0;
            qnext_ff[i]   <= NIL;
            qprev_ff[i]   <= NIL;
            tnext_ff[i]   <= NIL;
            tprev_ff[i]   <= NIL;
            tlinked_ff[i] <= 1'b0;
         end
         for (int j = 0; j < QUEUES; j++) begin
            qhead_ff[j]  <= NIL;
            qtail_ff[j]  <= NIL;
            qcount_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff        <= req_data;
                  cnt_ff        <= '0;
                  sum_status_ff <= 1'b1;
                  sum_reason_ff <= RSN_NONE;
                  sum_gen_ff    <= '0;
               end
            end
            ST_EXEC: begin
               unique case (req_ff.action)
                  ACT_WAKE_ONE, ACT_WAKE_ALL, ACT_CANCEL, ACT_EXPIRE: begin
                     sum_status_ff <= !(state_in != ST_DONE);
                  end
                  ACT_ABANDON: begin
                     if (do_cmp) begin
                        sum_status_ff <= 1'b0;
                        sum_reason_ff <= RSN_CANCELLED;
                     end
                  end
                  ACT_TAKE: begin
                     if (s_ok && sstate_ff[ra] == SS_COMPLETED) begin
                        sum_status_ff  <= 1'b0;
                        sum_reason_ff  <= sreason_ff[ra];
                        sstate_ff[ra]  <= SS_IDLE;
                        sreason_ff[ra] <= RSN_NONE;
                        stimed_ff[ra]  <= 1'b0;
                        qnext_ff[ra]   <= NIL;
                        qprev_ff[ra]   <= NIL;
                        tnext_ff[ra]   <= NIL;
                        tprev_ff[ra]   <= NIL;
                        tlinked_ff[ra] <= 1'b0;
                     end else begin
                        sum_reason_ff <= RSN_INTERRUPTED;
                     end
                  end
                  default: ;
               endcase
            end
            ST_PADD: begin
               // append to the queue tail and arm the slot
               sum_status_ff  <= 1'b0;
               sum_gen_ff     <= gen_new;
               sgen_ff[ra]    <= gen_new;
               squeue_ff[ra]  <= q_idx;
               qprev_ff[ra]   <= qtail_ff[q_idx];
               qnext_ff[ra]   <= NIL;
               tprev_ff[ra]   <= NIL;
               tnext_ff[ra]   <= NIL;
               tlinked_ff[ra] <= 1'b0;
               sdl_ff[ra]     <= dl_sum;
               newdl_ff       <= dl_sum;
               sreason_ff[ra] <= RSN_NONE;
               sstate_ff[ra]  <= SS_WAITING;
               stimed_ff[ra]  <= !req_ff.infinite;
               if (qtail_ff[q_idx] < NIL)
                  qnext_ff[qtail_ff[q_idx][SW-1:0]] <= PW'(s_idx);
               else
                  qhead_ff[q_idx] <= PW'(s_idx);
               qtail_ff[q_idx]  <= PW'(s_idx);
               qcount_ff[q_idx] <= qcount_ff[q_idx] + PW'(1);
               cur_ff  <= thead_ff;
               prev_ff <= NIL;
            end
            ST_PWALK: begin
               if (cur_ff >= NIL || cmp_before) begin
                  // insert the new slot between prev and cur
                  tprev_ff[s_idx]   <= prev_ff;
                  tnext_ff[s_idx]   <= cur_ff;
                  tlinked_ff[s_idx] <= 1'b1;
                  if (prev_ff < NIL)
                     tnext_ff[prev_ff[SW-1:0]] <= PW'(s_idx);
                  else
                     thead_ff <= PW'(s_idx);
                  if (cur_ff < NIL)
                     tprev_ff[cur_ff[SW-1:0]] <= PW'(s_idx);
               end else begin
                  prev_ff <= cur_ff;
                  cur_ff  <= tnext_ff[ra];
               end
            end
            ST_DONE: begin
               rsp_valid_ff         <= 1'b1;
               rsp_ff.status        <= sum_status_ff;
               rsp_ff.runnable      <= 1'b0;
               rsp_ff.woken_slot    <= '0;
               rsp_ff.wake_reason   <= sum_reason_ff;
               rsp_ff.woken_count   <= cnt_ff;
               rsp_ff.generation    <= sum_gen_ff;
               rsp_ff.last          <= 1'b1;
            end
            default: ;
         endcase

         if (do_cmp) begin
            // unlink from the wait queue
            if (c_p < NIL) qnext_ff[c_p[SW-1:0]] <= c_n;
            else           qhead_ff[c_q] <= c_n;
            if (c_n < NIL) qprev_ff[c_n[SW-1:0]] <= c_p;
            else           qtail_ff[c_q] <= c_p;
            if (qcount_ff[c_q] != '0) qcount_ff[c_q] <= qcount_ff[c_q] - PW'(1);
            qprev_ff[ra] <= NIL;
            qnext_ff[ra] <= NIL;
            // unlink from the timer list
            if (tlinked_ff[ra]) begin
               if (c_tp < NIL) tnext_ff[c_tp[SW-1:0]] <= c_tn;
               else            thead_ff <= c_tn;
               if (c_tn < NIL) tprev_ff[c_tn[SW-1:0]] <= c_tp;
               tprev_ff[ra]   <= NIL;
               tnext_ff[ra]   <= NIL;
               tlinked_ff[ra] <= 1'b0;
            end
            sreason_ff[ra] <= cmp_reason;
            sstate_ff[ra]  <= SS_COMPLETED;
            // report runnable slots; abandon stays silent
            if (state_ff != ST_EXEC) begin
               cnt_ff               <= cnt_ff + 5'd1;
               rsp_valid_ff         <= 1'b1;
               rsp_ff.status        <= 1'b0;
               rsp_ff.runnable      <= 1'b1;
               rsp_ff.woken_slot    <= 4'(ra);
               rsp_ff.wake_reason   <= cmp_reason;
               rsp_ff.woken_count   <= '0;
               rsp_ff.generation    <= '0;
               rsp_ff.last          <= 1'b0;
            end
         end
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
